[design/ftsrd_pkg.sv]
// ----------------------------------------------------------------------------
// ftsrd_pkg: shared types and constants
// Request and result structs, register indexes and reset values for the
// face track servo and rocking detector.
// ----------------------------------------------------------------------------
package ftsrd_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_GAP_LIMIT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROCK_THRESH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_MS      = 3'd4;

    localparam logic [7:0]  GAP_LIMIT_RST    = 8'd2;
    localparam logic [7:0]  WINDOW_LIMIT_RST = 8'd7;
    localparam logic [23:0] ROCK_THRESH_RST  = 24'd131072;
    localparam logic [15:0] GAIN_RST         = 16'd3932;
    localparam logic [15:0] HOLD_MS_RST      = 16'd1000;

    localparam logic [15:0] HALF_Q16 = 16'h8000;
    localparam logic [23:0] SUM_MAX  = 24'hFF_FFFF;

    // Past this many whole seconds the elapsed time exceeds any hold_ms.
    localparam int HOLD_MAX_MS   = 65535;
    localparam int MS_FIELD_MAX  = 1023;
    localparam int HOLD_SEC_LIM  = (HOLD_MAX_MS + MS_FIELD_MAX + 999) / 1000;
    localparam int HOLD_SEC_W    = 7;
    localparam int ELAPSED_W     = 19;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [15:0] face_x;
        logic [15:0] face_y;
        logic [31:0] now_sec;
        logic [9:0]  now_ms;
    } in_t;

    typedef struct packed {
        logic               servo_valid;
        logic signed [31:0] pan_pos;
        logic signed [31:0] tilt_pos;
        logic               rock_detected;
        logic               rock_cleared;
    } out_t;

endpackage

[design/ftsrd_axis.sv]
// ----------------------------------------------------------------------------
// ftsrd_axis: one servo axis integrator
// Adds floor(err * gain / 2^16) to the accumulator with signed saturation.
// ----------------------------------------------------------------------------
module ftsrd_axis (
    input  logic signed [17:0] err,
    input  logic        [15:0] gain,
    input  logic signed [31:0] acc,
    output logic signed [31:0] acc_sum
);

    logic signed [34:0] prod;
    logic signed [18:0] step;
    logic signed [32:0] sum;

    always_comb begin
        prod = 35'(err) * 35'(signed'({1'b0, gain}));
        step = prod[34:16];
        sum  = 33'(acc) + 33'(step);
        if (sum[32] != sum[31]) begin
            acc_sum = sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            acc_sum = sum[31:0];
        end
    end

endmodule

[design/face_track_servo_rock_detect.sv]
// ----------------------------------------------------------------------------
// face_track_servo_rock_detect: pan/tilt integrator with rocking detector
// Face samples set the pan/tilt error and run the rocking detector; control
// ticks within hold_ms of the last sample integrate the error into saturating positions.
//
//   channel  ports                        dir  payload
//   s_       s_valid s_ready s_data       in   ftsrd_pkg::in_t
//   m_       m_valid m_ready m_data       out  ftsrd_pkg::out_t
//   cfg_     cfg_wr_en cfg_index cfg_wdata in  register write, no wait
//
// One request per cycle while s_ready is high; a request loads the request
// register at acceptance and moves to the result register once that is free.
// Each request reads the state left by the previous one in a single pass.
// Reset: synchronous, active low; all but the request and result data registers take their default values.
// A stalled result holds the result and state; s_ready drops only when both registers are full.
// ----------------------------------------------------------------------------
module face_track_servo_rock_detect (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  ftsrd_pkg::in_t                      s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output ftsrd_pkg::out_t                     m_data,
    input  logic                                cfg_wr_en,
    input  logic [ftsrd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ftsrd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    logic [7:0]  gap_limit_reg;
    logic [7:0]  window_limit_reg;
    logic [23:0] rock_thresh_reg;
    logic [15:0] gain_reg;
    logic [15:0] hold_ms_reg;

    ftsrd_pkg::in_t  in_reg;
    logic            in_valid_reg;
    ftsrd_pkg::out_t out_reg;
    logic            out_valid_reg;

    logic signed [17:0] err_x_reg, err_x_next;
    logic signed [17:0] err_y_reg, err_y_next;
    logic [31:0] last_sec_reg, last_sec_next;
    logic [9:0]  last_ms_reg, last_ms_next;
    logic [31:0] win_start_reg, win_start_next;
    logic [23:0] rock_sum_reg, rock_sum_next;
    logic [15:0] prev_x_reg, prev_x_next;
    logic [15:0] prev_y_reg, prev_y_next;
    logic signed [31:0] pan_acc_reg, pan_acc_next;
    logic signed [31:0] tilt_acc_reg, tilt_acc_next;
    ftsrd_pkg::out_t out_next;

    logic        advance;
    logic        fire;
    logic        s_take;
    logic [31:0] gap_sec;
    logic [31:0] win_sec;
    logic [15:0] dx;
    logic [15:0] dy;
    logic [25:0] sum_wide;
    logic        timeout;
    logic        near;
    logic [16:0] sec_ms;
    logic signed [ftsrd_pkg::ELAPSED_W-1:0] elapsed;
    logic        active;
    logic signed [31:0] pan_sum;
    logic signed [31:0] tilt_sum;

    assign advance = !out_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;
    assign s_take  = s_valid && s_ready;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    ftsrd_axis u_pan (
        .err     (err_x_reg),
        .gain    (gain_reg),
        .acc     (pan_acc_reg),
        .acc_sum (pan_sum)
    );

    ftsrd_axis u_tilt (
        .err     (err_y_reg),
        .gain    (gain_reg),
        .acc     (tilt_acc_reg),
        .acc_sum (tilt_sum)
    );

    always_comb begin
        gap_sec  = in_reg.now_sec - last_sec_reg;
        win_sec  = in_reg.now_sec - win_start_reg;
        dx       = (in_reg.face_x > prev_x_reg) ? in_reg.face_x - prev_x_reg
                                                : prev_x_reg - in_reg.face_x;
        dy       = (in_reg.face_y > prev_y_reg) ? in_reg.face_y - prev_y_reg
                                                : prev_y_reg - in_reg.face_y;
        sum_wide = 26'(rock_sum_reg) + 26'(dx) + 26'(dy);
        timeout  = (gap_sec > 32'(gap_limit_reg)) || (win_sec > 32'(window_limit_reg));

        near     = gap_sec < 32'(ftsrd_pkg::HOLD_SEC_LIM);
        sec_ms   = 17'(gap_sec[ftsrd_pkg::HOLD_SEC_W-1:0]) * 17'd1000;
        elapsed  = signed'(ftsrd_pkg::ELAPSED_W'(sec_ms))
                 + signed'(ftsrd_pkg::ELAPSED_W'(in_reg.now_ms))
                 - signed'(ftsrd_pkg::ELAPSED_W'(last_ms_reg));
        active   = near && (elapsed < signed'(ftsrd_pkg::ELAPSED_W'(hold_ms_reg)));

        err_x_next     = err_x_reg;
        err_y_next     = err_y_reg;
        last_sec_next  = last_sec_reg;
        last_ms_next   = last_ms_reg;
        win_start_next = win_start_reg;
        rock_sum_next  = rock_sum_reg;
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        pan_acc_next   = pan_acc_reg;
        tilt_acc_next  = tilt_acc_reg;
        out_next       = '0;

        if (in_reg.req_type == ftsrd_pkg::REQ_SAMPLE) begin
            err_x_next    = signed'(18'(ftsrd_pkg::HALF_Q16)) - signed'(18'(in_reg.face_x));
            err_y_next    = signed'(18'(in_reg.face_y)) - signed'(18'(ftsrd_pkg::HALF_Q16));
            if (timeout) begin
                rock_sum_next         = '0;
                win_start_next        = in_reg.now_sec;
                out_next.rock_cleared = 1'b1;
            end else if (rock_sum_reg > rock_thresh_reg) begin
                rock_sum_next          = '0;
                win_start_next         = in_reg.now_sec;
                out_next.rock_detected = 1'b1;
            end else begin
                rock_sum_next = (sum_wide[25:24] != 2'b00) ? ftsrd_pkg::SUM_MAX
                                                           : sum_wide[23:0];
            end
            prev_x_next   = in_reg.face_x;
            prev_y_next   = in_reg.face_y;
            last_sec_next = in_reg.now_sec;
            last_ms_next  = in_reg.now_ms;
        end else if (active) begin
            pan_acc_next         = pan_sum;
            tilt_acc_next        = tilt_sum;
            out_next.servo_valid = 1'b1;
        end
        out_next.pan_pos  = pan_acc_next;
        out_next.tilt_pos = tilt_acc_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gap_limit_reg    <= ftsrd_pkg::GAP_LIMIT_RST;
            window_limit_reg <= ftsrd_pkg::WINDOW_LIMIT_RST;
            rock_thresh_reg  <= ftsrd_pkg::ROCK_THRESH_RST;
            gain_reg         <= ftsrd_pkg::GAIN_RST;
            hold_ms_reg      <= ftsrd_pkg::HOLD_MS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                ftsrd_pkg::REG_GAP_LIMIT:    gap_limit_reg    <= cfg_wdata[7:0];
                ftsrd_pkg::REG_WINDOW_LIMIT: window_limit_reg <= cfg_wdata[7:0];
                ftsrd_pkg::REG_ROCK_THRESH:  rock_thresh_reg  <= cfg_wdata[23:0];
                ftsrd_pkg::REG_GAIN:         gain_reg         <= cfg_wdata[15:0];
                ftsrd_pkg::REG_HOLD_MS:      hold_ms_reg      <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            err_x_reg     <= '0;
            err_y_reg     <= '0;
            last_sec_reg  <= '0;
            last_ms_reg   <= '0;
            win_start_reg <= '0;
            rock_sum_reg  <= '0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            pan_acc_reg   <= '0;
            tilt_acc_reg  <= '0;
        end else begin
            if (s_take) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (fire) begin
                err_x_reg     <= err_x_next;
                err_y_reg     <= err_y_next;
                last_sec_reg  <= last_sec_next;
                last_ms_reg   <= last_ms_next;
                win_start_reg <= win_start_next;
                rock_sum_reg  <= rock_sum_next;
                prev_x_reg    <= prev_x_next;
                prev_y_reg    <= prev_y_next;
                pan_acc_reg   <= pan_acc_next;
                tilt_acc_reg  <= tilt_acc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_reg <= s_data;
        end
        if (fire) begin
            out_reg <= out_next;
        end
    end

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.rock_detected && m_data.rock_cleared))
        else $error("rock detected and cleared on one result");

    a_tick_no_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.servo_valid |-> !m_data.rock_detected && !m_data.rock_cleared)
        else $error("servo result carries rocking flags");

    a_stall_holds_state: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |=> $stable(pan_acc_reg) && $stable(rock_sum_reg))
        else $error("state moved while result stalled");

    a_restart_clears_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && (out_next.rock_detected || out_next.rock_cleared) |=> rock_sum_reg == '0)
        else $error("rocking sum not cleared on restart");

    a_result_tracks_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_data.pan_pos == pan_acc_reg && m_data.tilt_pos == tilt_acc_reg)
        else $error("result position differs from accumulator");

endmodule

[tb/ftsrd_servo_checker.sv]
// ----------------------------------------------------------------------------
// ftsrd_servo_checker: result predictor and comparator
// Watches the request, result and register write ports of the face track
// servo. It keeps its own copy of the tracking state and registers, works out
// the result of every accepted request and compares it field by field with
// the results that the block hands out, in order.
// ----------------------------------------------------------------------------
module ftsrd_servo_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  ftsrd_pkg::in_t                    s_data,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  ftsrd_pkg::out_t                   m_data,
    input  logic                              cfg_wr_en,
    input  logic [ftsrd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ftsrd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output int                                mismatch_count,
    output int                                pending_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import ftsrd_pkg::*;

    localparam longint ACC_MAX = 64'sd2147483647;
    localparam longint ACC_MIN = -64'sd2147483648;

    logic [7:0]  gap_lim;
    logic [7:0]  win_lim;
    logic [23:0] rock_thr;
    logic [15:0] gain_q;
    logic [15:0] hold_lim;

    int          err_x;
    int          err_y;
    logic [31:0] seen_sec;
    logic [9:0]  seen_ms;
    logic [31:0] win_start;
    logic [23:0] rock_sum;
    logic [15:0] prev_x;
    logic [15:0] prev_y;
    int          pan_acc;
    int          tilt_acc;

    out_t servo_expected[$];

    initial begin
        mismatch_count = 0;
        pending_count  = 0;
    end

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("%0t ns mismatch on %s: got %0h, predicted %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    function automatic int abs_gap(input logic [15:0] a, input logic [15:0] b);
        int da;
        int db;
        da = {16'd0, a};
        db = {16'd0, b};
        return (da > db) ? da - db : db - da;
    endfunction

    function automatic int clamp_acc(input longint v);
        if (v > ACC_MAX)
            return int'(ACC_MAX);
        if (v < ACC_MIN)
            return int'(ACC_MIN);
        return int'(v);
    endfunction

    function automatic out_t track_step(input in_t rq);
        out_t        r;
        logic [31:0] gap_s;
        logic [31:0] win_s;
        longint      sum_next;
        longint      elapsed;
        r = '0;
        if (rq.req_type == REQ_SAMPLE) begin
            gap_s = rq.now_sec - seen_sec;
            win_s = rq.now_sec - win_start;
            err_x = int'({16'd0, HALF_Q16}) - int'({16'd0, rq.face_x});
            err_y = int'({16'd0, rq.face_y}) - int'({16'd0, HALF_Q16});
            if (gap_s > {24'd0, gap_lim} || win_s > {24'd0, win_lim}) begin
                rock_sum       = '0;
                win_start      = rq.now_sec;
                r.rock_cleared = 1'b1;
            end else if (rock_sum > rock_thr) begin
                rock_sum        = '0;
                win_start       = rq.now_sec;
                r.rock_detected = 1'b1;
            end else begin
                sum_next = longint'({40'd0, rock_sum}) + abs_gap(rq.face_x, prev_x)
                           + abs_gap(rq.face_y, prev_y);
                rock_sum = (sum_next > longint'({40'd0, SUM_MAX})) ? SUM_MAX : sum_next[23:0];
            end
            prev_x   = rq.face_x;
            prev_y   = rq.face_y;
            seen_sec = rq.now_sec;
            seen_ms  = rq.now_ms;
        end else begin
            elapsed = longint'({32'd0, rq.now_sec - seen_sec}) * 1000
                      + longint'({54'd0, rq.now_ms}) - longint'({54'd0, seen_ms});
            if (elapsed < longint'({48'd0, hold_lim})) begin
                pan_acc  = clamp_acc(longint'(pan_acc)
                           + ((longint'(err_x) * longint'({48'd0, gain_q})) >>> 16));
                tilt_acc = clamp_acc(longint'(tilt_acc)
                           + ((longint'(err_y) * longint'({48'd0, gain_q})) >>> 16));
                r.servo_valid = 1'b1;
            end
        end
        r.pan_pos  = pan_acc;
        r.tilt_pos = tilt_acc;
        return r;
    endfunction

    always @(posedge aclk) begin
        out_t want;
        if (!aresetn) begin
            gap_lim   = GAP_LIMIT_RST;
            win_lim   = WINDOW_LIMIT_RST;
            rock_thr  = ROCK_THRESH_RST;
            gain_q    = GAIN_RST;
            hold_lim  = HOLD_MS_RST;
            err_x     = 0;
            err_y     = 0;
            seen_sec  = '0;
            seen_ms   = '0;
            win_start = '0;
            rock_sum  = '0;
            prev_x    = '0;
            prev_y    = '0;
            pan_acc   = 0;
            tilt_acc  = 0;
            servo_expected.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_GAP_LIMIT:    gap_lim  = cfg_wdata[7:0];
                    REG_WINDOW_LIMIT: win_lim  = cfg_wdata[7:0];
                    REG_ROCK_THRESH:  rock_thr = cfg_wdata[23:0];
                    REG_GAIN:         gain_q   = cfg_wdata[15:0];
                    REG_HOLD_MS:      hold_lim = cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                servo_expected.insert(servo_expected.size(), track_step(s_data));
            if (m_valid && m_ready) begin
                if (servo_expected.size() == 0) begin
                    flag_mismatch("unexpected result", 64'(unsigned'(m_data.pan_pos)), '0);
                end else begin
                    want = servo_expected.pop_front();
                    if (m_data.servo_valid !== want.servo_valid)
                        flag_mismatch("servo_valid", 64'(m_data.servo_valid),
                                      64'(want.servo_valid));
                    if (m_data.pan_pos !== want.pan_pos)
                        flag_mismatch("pan_pos", 64'(unsigned'(m_data.pan_pos)),
                                      64'(unsigned'(want.pan_pos)));
                    if (m_data.tilt_pos !== want.tilt_pos)
                        flag_mismatch("tilt_pos", 64'(unsigned'(m_data.tilt_pos)),
                                      64'(unsigned'(want.tilt_pos)));
                    if (m_data.rock_detected !== want.rock_detected)
                        flag_mismatch("rock_detected", 64'(m_data.rock_detected),
                                      64'(want.rock_detected));
                    if (m_data.rock_cleared !== want.rock_cleared)
                        flag_mismatch("rock_cleared", 64'(m_data.rock_cleared),
                                      64'(want.rock_cleared));
                end
            end
        end
        pending_count = servo_expected.size();
    end

endmodule

[tb/face_track_servo_rock_detect_tb.sv]
// ----------------------------------------------------------------------------
// face_track_servo_rock_detect_tb: regression bench for the face track servo
// Drives face samples and control ticks through the request channel with
// bursty traffic and a stalling result side, steps the registers through
// several settings including both extremes, and leaves result checking to
// the servo checker instance.
// ----------------------------------------------------------------------------
module face_track_servo_rock_detect_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ftsrd_pkg::*;

    localparam int STALL_LIMIT   = 4000;
    localparam int LONG_HOLD     = 80;
    localparam int PHASE_ITEMS   = 120;
    localparam int SUM_SAT_ITEMS = 130;
    localparam int SAT_TICKS     = 24;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_SHUT} rx_mode_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_t                   s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_t                  m_data;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int          mismatches;
    int          outstanding;
    int          quiet_cycles;
    bit          long_hold_due;
    logic [31:0] t_sec;
    logic [9:0]  t_ms;
    logic [15:0] at_x;
    logic [15:0] at_y;

    face_track_servo_rock_detect dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    ftsrd_servo_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatches),
        .pending_count  (outstanding)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side: random stretches of open, coin-flip or sparse, and a shut stretch when a long hold is due
    initial begin
        rx_mode_t mode;
        int       len;
        m_ready = 1'b0;
        forever begin
            if (long_hold_due) begin
                long_hold_due = 1'b0;
                mode = RX_SHUT;
                len  = LONG_HOLD;
            end else begin
                mode = rx_mode_t'($urandom_range(0, 2));
                len  = $urandom_range(5, 120);
            end
            repeat (len) begin
                @(negedge aclk);
                case (mode)
                    RX_OPEN:   m_ready <= 1'b1;
                    RX_COIN:   m_ready <= ($urandom_range(0, 1) == 0);
                    RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                    default:   m_ready <= 1'b0;
                endcase
            end
        end
    end

    function automatic in_t mk_req(input logic kind, input logic [15:0] x,
                                   input logic [15:0] y, input logic [31:0] sec,
                                   input logic [9:0] ms);
        in_t r;
        r.req_type = kind;
        r.face_x   = x;
        r.face_y   = y;
        r.now_sec  = sec;
        r.now_ms   = ms;
        return r;
    endfunction

    task automatic send_request(input in_t rq);
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= rq;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic pause_sender(input int n);
        @(negedge aclk);
        s_valid <= 1'b0;
        repeat (n - 1) @(negedge aclk);
    endtask

    task automatic drain();
        pause_sender(1);
        while (outstanding != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic load_settings(input logic [7:0] gap, input logic [7:0] win,
                                 input logic [23:0] thr, input logic [15:0] gain,
                                 input logic [15:0] hold);
        drain();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_GAP_LIMIT;
        cfg_wdata <= {16'd0, gap};
        @(negedge aclk);
        cfg_index <= REG_WINDOW_LIMIT;
        cfg_wdata <= {16'd0, win};
        @(negedge aclk);
        cfg_index <= REG_ROCK_THRESH;
        cfg_wdata <= thr;
        @(negedge aclk);
        cfg_index <= REG_GAIN;
        cfg_wdata <= {8'd0, gain};
        @(negedge aclk);
        cfg_index <= REG_HOLD_MS;
        cfg_wdata <= {8'd0, hold};
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // mostly forward time with small face motion, some jumps, rewinds and wraps
    task automatic gen_request(output in_t rq);
        int pick;
        int ms_sum;
        pick = $urandom_range(0, 99);
        if (pick < 72) begin
            ms_sum = int'({22'd0, t_ms}) + $urandom_range(0, 700);
            t_sec  = t_sec + ms_sum / 1000;
            t_ms   = 10'(ms_sum % 1000);
        end else if (pick < 86) begin
            t_sec = t_sec + $urandom_range(1, 12);
        end else if (pick < 93) begin
            t_sec = t_sec - $urandom_range(0, 2);
        end else if (pick < 97) begin
            t_sec = $urandom();
        end else begin
            t_sec = 32'hFFFF_FFFF - $urandom_range(0, 3);
        end
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            at_x = at_x + 16'($urandom_range(0, 4000)) - 16'd2000;
            at_y = at_y + 16'($urandom_range(0, 4000)) - 16'd2000;
        end else if (pick < 85) begin
            at_x = 16'($urandom());
            at_y = 16'($urandom());
        end else begin
            at_x = pick[0] ? 16'hFFFF : 16'h0000;
            at_y = pick[1] ? 16'hFFFF : HALF_Q16;
        end
        rq.req_type = ($urandom_range(0, 1) == 0) ? REQ_SAMPLE : REQ_TICK;
        rq.face_x   = (rq.req_type == REQ_SAMPLE) ? at_x : 16'($urandom());
        rq.face_y   = (rq.req_type == REQ_SAMPLE) ? at_y : 16'($urandom());
        rq.now_sec  = t_sec;
        rq.now_ms   = ($urandom_range(0, 24) == 0) ? 10'($urandom_range(1000, 1023)) : t_ms;
    endtask

    task automatic run_random(input int n);
        in_t rq;
        int  sent;
        int  burst;
        int  gap;
        sent = 0;
        long_hold_due = 1'b1;
        while (sent < n) begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && sent < n; k++) begin
                gen_request(rq);
                send_request(rq);
                sent++;
            end
            gap = $urandom_range(0, 11);
            if (gap == 0)
                drain();
            else if (gap > 3)
                pause_sender($urandom_range(1, 12));
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        quiet_cycles  = 0;
        long_hold_due = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: rocking detect, hold window edges, wrap, late ms
        send_request(mk_req(REQ_SAMPLE, 16'h0000, 16'h0000, 32'd0, 10'd0));
        send_request(mk_req(REQ_SAMPLE, 16'hFFFF, 16'hFFFF, 32'd1, 10'd0));
        send_request(mk_req(REQ_SAMPLE, 16'h0000, 16'h0000, 32'd1, 10'd500));
        send_request(mk_req(REQ_SAMPLE, HALF_Q16, HALF_Q16, 32'd2, 10'd0));
        send_request(mk_req(REQ_SAMPLE, 16'h0000, 16'hFFFF, 32'd2, 10'd100));
        send_request(mk_req(REQ_TICK,   16'h0000, 16'h0000, 32'd2, 10'd600));
        send_request(mk_req(REQ_TICK,   16'h0000, 16'h0000, 32'd3, 10'd100));
        send_request(mk_req(REQ_TICK,   16'h0000, 16'h0000, 32'd2, 10'd50));
        send_request(mk_req(REQ_SAMPLE, 16'hFFFF, 16'h0000, 32'd2, 10'd200));
        send_request(mk_req(REQ_TICK,   16'h0000, 16'h0000, 32'd2, 10'd201));
        send_request(mk_req(REQ_SAMPLE, HALF_Q16, HALF_Q16, 32'd5, 10'd0));
        for (int s = 7; s <= 13; s++)
            send_request(mk_req(REQ_SAMPLE, HALF_Q16 + 16'(s * 64), HALF_Q16, 32'(s), 10'd0));
        send_request(mk_req(REQ_SAMPLE, 16'h1234, 16'hEDCB, 32'hFFFF_FFFF, 10'd999));
        send_request(mk_req(REQ_TICK,   16'h0000, 16'h0000, 32'd0, 10'd10));
        send_request(mk_req(REQ_SAMPLE, 16'h1300, 16'hEC00, 32'd0, 10'd1023));
        send_request(mk_req(REQ_TICK,   16'h0000, 16'h0000, 32'd1, 10'd0));
        send_request(mk_req(REQ_TICK,   16'h0000, 16'h0000, 32'd1, 10'd1023));
        t_sec = 32'd1;
        t_ms  = 10'd0;
        at_x  = HALF_Q16;
        at_y  = HALF_Q16;

        load_settings(8'd0, 8'd0, 24'd0, 16'd0, 16'd0);
        run_random(PHASE_ITEMS);

        // top settings: saturate the rocking sum, then ticks at full gain
        load_settings(8'hFF, 8'hFF, SUM_MAX, 16'hFFFF, 16'hFFFF);
        t_sec = t_sec + 32'd300;
        for (int k = 0; k < SUM_SAT_ITEMS; k++)
            send_request(mk_req(REQ_SAMPLE, k[0] ? 16'hFFFF : 16'h0000,
                                k[0] ? 16'hFFFF : 16'h0000, t_sec, t_ms));
        send_request(mk_req(REQ_SAMPLE, 16'h0000, 16'h0000, t_sec, t_ms));
        for (int k = 0; k < SAT_TICKS; k++)
            send_request(mk_req(REQ_TICK, 16'($urandom()), 16'($urandom()), t_sec, t_ms));
        send_request(mk_req(REQ_SAMPLE, 16'hFFFF, 16'hFFFF, t_sec, t_ms));
        for (int k = 0; k < 20; k++)
            send_request(mk_req(REQ_TICK, 16'h0000, 16'h0000, t_sec, t_ms));
        run_random(PHASE_ITEMS);

        repeat (3) begin
            load_settings(8'($urandom_range(0, 6)), 8'($urandom_range(0, 14)),
                          24'($urandom_range(0, 300000)), 16'($urandom()),
                          16'($urandom_range(0, 4000)));
            run_random(PHASE_ITEMS);
        end

        load_settings(GAP_LIMIT_RST, WINDOW_LIMIT_RST, ROCK_THRESH_RST, GAIN_RST, HOLD_MS_RST);
        run_random(PHASE_ITEMS);

        pause_sender(1);
        while (outstanding != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
